// ----- design/perlin_noise_2d_terrain_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 2D gradient noise terrain block
// Shared check forms; each use expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PERLIN_NOISE_2D_TERRAIN_DEFINES_SVH
`define PERLIN_NOISE_2D_TERRAIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PN2D_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PN2D_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// pn2d_pkg
// Field widths, opcodes, gradient codes and the gradient select function.
// ----------------------------------------------------------------------------
package pn2d_pkg;

    localparam int COORD_W    = 32;
    localparam int IDX_W      = 8;
    localparam int PERM_W     = 8;
    localparam int TABLE_SIZE = 256;
    localparam int CELL_MOD   = TABLE_SIZE - 1;
    localparam int NOISE_W    = 19;
    localparam int HEIGHT_W   = 4;

    localparam int NOISE_MAX  = 262143;
    localparam int NOISE_MIN  = -262144;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [HEIGHT_W-1:0] HEIGHT_LOW  = 4'd0;
    localparam logic [HEIGHT_W-1:0] HEIGHT_HIGH = 4'd10;

    typedef enum logic [1:0] {
        GRAD_PP = 2'd0,   // ( 1,  1)
        GRAD_NP = 2'd1,   // (-1,  1)
        GRAD_NN = 2'd2    // (-1, -1)
    } grad_t;

    // hash mod 3: base-4 digits sum to the same residue
    function automatic grad_t grad_sel(input logic [PERM_W-1:0] hash);
        logic [3:0] digit_sum;
        grad_t      sel;
        digit_sum = 4'(hash[1:0]) + 4'(hash[3:2]) + 4'(hash[5:4]) + 4'(hash[7:6]);
        if (digit_sum inside {4'd0, 4'd3, 4'd6, 4'd9, 4'd12})
        begin
            sel = GRAD_PP;
        end
        else if (digit_sum inside {4'd1, 4'd4, 4'd7, 4'd10})
        begin
            sel = GRAD_NP;
        end
        else
        begin
            sel = GRAD_NN;
        end
        return sel;
    endfunction

endpackage

// ----- design/pn2d_if.sv -----
// ----------------------------------------------------------------------------
// pn2d channel interfaces
// Command channel (table writes and samples) and result channel.
// ----------------------------------------------------------------------------
interface pn2d_cmd_if;
    import pn2d_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [IDX_W-1:0]   table_index;
    logic [PERM_W-1:0]  table_value;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;

    modport source (
        output valid, opcode, table_index, table_value, coord_x, coord_y,
        input  ready
    );

    modport sink (
        input  valid, opcode, table_index, table_value, coord_x, coord_y,
        output ready
    );
endinterface

interface pn2d_result_if;
    import pn2d_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [NOISE_W-1:0]  noise_value;
    logic [HEIGHT_W-1:0]        terrain_height;
    logic                       passable;

    modport source (
        output valid, noise_value, terrain_height, passable,
        input  ready
    );

    modport sink (
        input  valid, noise_value, terrain_height, passable,
        output ready
    );
endinterface

// ----- design/perlin_noise_2d_terrain.sv -----
// ----------------------------------------------------------------------------
// perlin_noise_2d_terrain
// 2D gradient noise sampler with terrain height quantization.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries two kinds of item. A table write (opcode 0) stores one byte
//   of the 256-entry permutation table and produces no result. A sample
//   (opcode 1) takes unsigned fixed-point x/y coordinates and produces one
//   item on result: noise value, height level 0..10 and a passable flag.
//   An item is taken on a rising edge with valid and ready both high.
// Throughput: one item per cycle, back to back, writes and samples mixed,
//   while result is not held. Pipeline: a sample passes nine register
//   stages, the first loaded at the accepting edge: the 6t - 15 seed, four
//   chained fade multiplies, the inner lerp, the span subtract, the outer
//   lerp with saturation, and the height stage.
// Table: three copies of the table (one for the first hash level, two for
//   the corner lookups) all see every write, each at the stage where it is
//   read, so a sample always sees exactly the writes accepted before it.
// Reset: clears all stage valid bits; table contents are not cleared and
//   must be loaded before sampling.
// Stall: a held result keeps its output register; stages behind it keep
//   filling empty slots, and cmd.ready drops once stage 1 cannot move.
// ----------------------------------------------------------------------------
`include "perlin_noise_2d_terrain_defines.svh"

module perlin_noise_2d_terrain #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    pn2d_cmd_if.sink        cmd,
    pn2d_result_if.source   result
);
    import pn2d_pkg::*;

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int IW   = COORD_W - FRAC_BITS;  // integer part of a coordinate
    localparam int NB   = (IW + 7) / 8;          // bytes in the integer part
    localparam int PADW = NB * 8;
    localparam int AW   = FRAC_BITS + 5;         // fade accumulator, signed
    localparam int TW   = FRAC_BITS + 1;         // fraction as signed
    localparam int PW   = AW + TW;               // fade product
    localparam int UW   = FRAC_BITS + 2;         // fade output 0..1
    localparam int DW   = FRAC_BITS + 3;         // corner dot product
    localparam int DFW  = FRAC_BITS + 4;         // dot difference
    localparam int LW   = FRAC_BITS + 4;         // inner lerp value
    localparam int LDW  = FRAC_BITS + 5;         // lerp span
    localparam int QW   = UW + LDW;              // lerp product
    localparam int NW   = FRAC_BITS + 5;         // noise before saturation
    localparam int SW   = (NW > NOISE_W) ? NW : NOISE_W;
    localparam int HW   = ((FRAC_BITS > NOISE_W) ? FRAC_BITS : NOISE_W) + 8;

    localparam logic signed [AW-1:0] FIFTEEN_ONE = AW'(15 << FRAC_BITS);
    localparam logic signed [AW-1:0] TEN_ONE     = AW'(10 << FRAC_BITS);
    localparam logic signed [DW-1:0] ONE_DOT     = DW'(1 << FRAC_BITS);
    localparam logic signed [SW-1:0] SAT_HI      = SW'(NOISE_MAX);
    localparam logic signed [SW-1:0] SAT_LO      = SW'(NOISE_MIN);
    localparam logic signed [HW-1:0] FOUR_ONE    = HW'(4 << FRAC_BITS);
    localparam logic signed [HW-1:0] HALF_ONE    = HW'(1 << (FRAC_BITS - 1));
    localparam logic signed [HW-1:0] HIGH_CLAMP  =
        HW'((9 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));

    // ------------------------------------------------------------------
    // Arithmetic helpers
    // ------------------------------------------------------------------
    // integer part mod 255: 256 = 1 (mod 255), so sum bytes and fold
    function automatic logic [IDX_W-1:0] cell_mod(input logic [IW-1:0] ipart);
        logic [PADW-1:0] padded;
        logic [9:0]      byte_sum;
        logic [8:0]      folded;
        padded   = PADW'(ipart);
        byte_sum = '0;
        for (int i = 0; i < NB; i++)
        begin
            byte_sum = byte_sum + 10'(padded[i*8 +: 8]);
        end
        folded = 9'(byte_sum[7:0]) + 9'(byte_sum[9:8]);
        if (folded >= 9'(CELL_MOD))
        begin
            folded = folded - 9'(CELL_MOD);
        end
        return folded[IDX_W-1:0];
    endfunction

    // 6t - 15, first term of the fade polynomial
    function automatic logic signed [AW-1:0] fade_seed(input logic [FRAC_BITS-1:0] t);
        logic signed [AW-1:0] t_ext;
        t_ext = $signed(AW'({1'b0, t}));
        return (t_ext <<< 2) + (t_ext <<< 1) - FIFTEEN_ONE;
    endfunction

    // acc * t, floored to FRAC_BITS fraction bits
    function automatic logic signed [AW-1:0] fade_mul(
        input logic signed [AW-1:0]    acc,
        input logic [FRAC_BITS-1:0]    t
    );
        logic signed [PW-1:0] prod;
        prod = PW'(acc) * PW'($signed({1'b0, t}));
        return AW'(prod >>> FRAC_BITS);
    endfunction

    // w * span, floored
    function automatic logic signed [LDW-1:0] lerp_step(
        input logic signed [UW-1:0]  w,
        input logic signed [LDW-1:0] span
    );
        logic signed [QW-1:0] prod;
        prod = QW'(w) * QW'(span);
        return LDW'(prod >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DW-1:0] grad_dot(
        input grad_t                sel,
        input logic signed [DW-1:0] dx,
        input logic signed [DW-1:0] dy
    );
        logic signed [DW-1:0] dot;
        case (sel)
            GRAD_PP: dot = dx + dy;
            GRAD_NP: dot = dy - dx;
            default: dot = -dx - dy;
        endcase
        return dot;
    endfunction

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    // S1: decoded input, fade seed
    logic                        s1_v_reg, s1_op_reg;
    logic [IDX_W-1:0]            s1_idx_reg, s1_cx_reg, s1_cy_reg;
    logic [PERM_W-1:0]           s1_val_reg;
    logic [FRAC_BITS-1:0]        s1_xf_reg, s1_yf_reg;
    logic signed [AW-1:0]        s1_ax_reg, s1_ay_reg;
    // S2: first-level hashes, fade step 1
    logic                        s2_v_reg, s2_op_reg;
    logic [IDX_W-1:0]            s2_idx_reg, s2_cy_reg;
    logic [PERM_W-1:0]           s2_val_reg, s2_p0_reg, s2_p1_reg;
    logic [FRAC_BITS-1:0]        s2_xf_reg, s2_yf_reg;
    logic signed [AW-1:0]        s2_mx_reg, s2_my_reg;
    // S3: corner hashes, fade step 2
    logic                        s3_v_reg;
    logic [PERM_W-1:0]           s3_hbl_reg, s3_htl_reg, s3_hbr_reg, s3_htr_reg;
    logic [FRAC_BITS-1:0]        s3_xf_reg, s3_yf_reg;
    logic signed [AW-1:0]        s3_mx_reg, s3_my_reg;
    // S4: corner dots, fade step 3
    logic                        s4_v_reg;
    logic signed [DW-1:0]        s4_dbl_reg, s4_dtl_reg, s4_dbr_reg, s4_dtr_reg;
    logic [FRAC_BITS-1:0]        s4_xf_reg, s4_yf_reg;
    logic signed [AW-1:0]        s4_mx_reg, s4_my_reg;
    // S5: fade outputs, dot spans
    logic                        s5_v_reg;
    logic signed [UW-1:0]        s5_fu_reg, s5_fv_reg;
    logic signed [DW-1:0]        s5_dbl_reg, s5_dbr_reg;
    logic signed [DFW-1:0]       s5_dif0_reg, s5_dif1_reg;
    // S6: inner lerps
    logic                        s6_v_reg;
    logic signed [UW-1:0]        s6_fu_reg;
    logic signed [LW-1:0]        s6_l0_reg, s6_l1_reg;
    // S7: outer lerp operands
    logic                        s7_v_reg;
    logic signed [UW-1:0]        s7_fu_reg;
    logic signed [LW-1:0]        s7_l0_reg;
    logic signed [LDW-1:0]       s7_ldiff_reg;
    // S8: saturated noise
    logic                        s8_v_reg;
    logic signed [NOISE_W-1:0]   s8_noise_reg;
    // output register
    logic                        res_v_reg;
    logic signed [NOISE_W-1:0]   res_noise_reg;
    logic [HEIGHT_W-1:0]         res_height_reg;
    logic                        res_pass_reg;

    // stage load enables: a stage loads when empty or when it moves on
    logic en1, en2, en3, en4, en5, en6, en7, en8, en_out;

    assign en_out = !res_v_reg || result.ready;
    assign en8    = !s8_v_reg  || en_out;
    assign en7    = !s7_v_reg  || en8;
    assign en6    = !s6_v_reg  || en7;
    assign en5    = !s5_v_reg  || en6;
    assign en4    = !s4_v_reg  || en5;
    assign en3    = !s3_v_reg  || en4;
    assign en2    = !s2_v_reg  || en3;
    assign en1    = !s1_v_reg  || en2;

    assign cmd.ready = en1;

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]          s1_cx_next, s1_cy_next;
    logic signed [AW-1:0]      s1_ax_next, s1_ay_next;
    logic [IDX_W-1:0]          cx_plus, cy_plus;
    logic [IDX_W-1:0]          addr_bl, addr_tl, addr_br, addr_tr;
    logic signed [AW-1:0]      s2_mx_next, s2_my_next;
    logic signed [AW-1:0]      s3_mx_next, s3_my_next;
    logic signed [DW-1:0]      dx0, dx1, dy0, dy1;
    logic signed [DW-1:0]      s4_dbl_next, s4_dtl_next, s4_dbr_next, s4_dtr_next;
    logic signed [AW-1:0]      s4_mx_next, s4_my_next;
    logic signed [UW-1:0]      s5_fu_next, s5_fv_next;
    logic signed [DFW-1:0]     s5_dif0_next, s5_dif1_next;
    logic signed [LW-1:0]      s6_l0_next, s6_l1_next;
    logic signed [LDW-1:0]     s7_ldiff_next;
    logic signed [NW-1:0]      noise_full;
    logic signed [SW-1:0]      noise_ext;
    logic signed [NOISE_W-1:0] s8_noise_next;
    logic signed [HW-1:0]      height_fx, height_round;
    logic [HEIGHT_W-1:0]       res_height_next;
    logic                      res_pass_next;
    logic                      l1_we, l2_we;

    always_comb
    begin
        // S0 -> S1: cell indices and fade seed
        s1_cx_next = cell_mod(cmd.coord_x[COORD_W-1:FRAC_BITS]);
        s1_cy_next = cell_mod(cmd.coord_y[COORD_W-1:FRAC_BITS]);
        s1_ax_next = fade_seed(cmd.coord_x[FRAC_BITS-1:0]);
        s1_ay_next = fade_seed(cmd.coord_y[FRAC_BITS-1:0]);

        // S1 -> S2
        cx_plus    = s1_cx_reg + 8'd1;
        s2_mx_next = fade_mul(s1_ax_reg, s1_xf_reg) + TEN_ONE;
        s2_my_next = fade_mul(s1_ay_reg, s1_yf_reg) + TEN_ONE;

        // S2 -> S3: corner lookup addresses wrap at 256
        cy_plus    = s2_cy_reg + 8'd1;
        addr_bl    = s2_p0_reg + s2_cy_reg;
        addr_tl    = s2_p0_reg + cy_plus;
        addr_br    = s2_p1_reg + s2_cy_reg;
        addr_tr    = s2_p1_reg + cy_plus;
        s3_mx_next = fade_mul(s2_mx_reg, s2_xf_reg);
        s3_my_next = fade_mul(s2_my_reg, s2_yf_reg);

        // S3 -> S4: offsets to the four corners
        dx0         = $signed(DW'({1'b0, s3_xf_reg}));
        dy0         = $signed(DW'({1'b0, s3_yf_reg}));
        dx1         = dx0 - ONE_DOT;
        dy1         = dy0 - ONE_DOT;
        s4_dbl_next = grad_dot(grad_sel(s3_hbl_reg), dx0, dy0);
        s4_dtl_next = grad_dot(grad_sel(s3_htl_reg), dx0, dy1);
        s4_dbr_next = grad_dot(grad_sel(s3_hbr_reg), dx1, dy0);
        s4_dtr_next = grad_dot(grad_sel(s3_htr_reg), dx1, dy1);
        s4_mx_next  = fade_mul(s3_mx_reg, s3_xf_reg);
        s4_my_next  = fade_mul(s3_my_reg, s3_yf_reg);

        // S4 -> S5
        s5_fu_next   = UW'(fade_mul(s4_mx_reg, s4_xf_reg));
        s5_fv_next   = UW'(fade_mul(s4_my_reg, s4_yf_reg));
        s5_dif0_next = DFW'(s4_dtl_reg) - DFW'(s4_dbl_reg);
        s5_dif1_next = DFW'(s4_dtr_reg) - DFW'(s4_dbr_reg);

        // S5 -> S6: lerp along y
        s6_l0_next = LW'(s5_dbl_reg) + LW'(lerp_step(s5_fv_reg, LDW'(s5_dif0_reg)));
        s6_l1_next = LW'(s5_dbr_reg) + LW'(lerp_step(s5_fv_reg, LDW'(s5_dif1_reg)));

        // S6 -> S7
        s7_ldiff_next = LDW'(s6_l1_reg) - LDW'(s6_l0_reg);

        // S7 -> S8: lerp along x, saturate to the output field
        noise_full = NW'(s7_l0_reg) + NW'(lerp_step(s7_fu_reg, s7_ldiff_reg));
        noise_ext  = SW'(noise_full);
        if (noise_ext > SAT_HI)
        begin
            noise_ext = SAT_HI;
        end
        else if (noise_ext < SAT_LO)
        begin
            noise_ext = SAT_LO;
        end
        s8_noise_next = NOISE_W'(noise_ext);

        // S8 -> output: height = 16*noise + 4, round half up, clamp
        height_fx    = (HW'(s8_noise_reg) <<< 4) + FOUR_ONE;
        height_round = height_fx + HALF_ONE;
        if (height_fx <= HALF_ONE)
        begin
            res_height_next = HEIGHT_LOW;
            res_pass_next   = 1'b0;
        end
        else if (height_fx >= HIGH_CLAMP)
        begin
            res_height_next = HEIGHT_HIGH;
            res_pass_next   = 1'b0;
        end
        else
        begin
            res_height_next = HEIGHT_W'(height_round >>> FRAC_BITS);
            res_pass_next   = 1'b1;
        end
    end

    // table writes land in each copy at the stage that reads it
    assign l1_we = s1_v_reg && (s1_op_reg == OP_WRITE) && en2;
    assign l2_we = s2_v_reg && (s2_op_reg == OP_WRITE) && en3;

    // ------------------------------------------------------------------
    // Permutation table copies
    // ------------------------------------------------------------------
    logic [PERM_W-1:0] perm_l1_mem  [TABLE_SIZE];
    logic [PERM_W-1:0] perm_l2a_mem [TABLE_SIZE];
    logic [PERM_W-1:0] perm_l2b_mem [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (l1_we)
        begin
            perm_l1_mem[s1_idx_reg] <= s1_val_reg;
        end
        if (en2)
        begin
            s2_p0_reg <= perm_l1_mem[s1_cx_reg];
            s2_p1_reg <= perm_l1_mem[cx_plus];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            perm_l2a_mem[s2_idx_reg] <= s2_val_reg;
        end
        if (en3)
        begin
            s3_hbl_reg <= perm_l2a_mem[addr_bl];
            s3_htl_reg <= perm_l2a_mem[addr_tl];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            perm_l2b_mem[s2_idx_reg] <= s2_val_reg;
        end
        if (en3)
        begin
            s3_hbr_reg <= perm_l2b_mem[addr_br];
            s3_htr_reg <= perm_l2b_mem[addr_tr];
        end
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)    s1_v_reg  <= cmd.valid;
            if (en2)    s2_v_reg  <= s1_v_reg;
            // write items end here: their last table copy is written
            if (en3)    s3_v_reg  <= s2_v_reg && (s2_op_reg == OP_EVAL);
            if (en4)    s4_v_reg  <= s3_v_reg;
            if (en5)    s5_v_reg  <= s4_v_reg;
            if (en6)    s6_v_reg  <= s5_v_reg;
            if (en7)    s7_v_reg  <= s6_v_reg;
            if (en8)    s8_v_reg  <= s7_v_reg;
            if (en_out) res_v_reg <= s8_v_reg;
        end
    end

    // ------------------------------------------------------------------
    // Payload
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg  <= cmd.opcode;
            s1_idx_reg <= cmd.table_index;
            s1_val_reg <= cmd.table_value;
            s1_xf_reg  <= cmd.coord_x[FRAC_BITS-1:0];
            s1_yf_reg  <= cmd.coord_y[FRAC_BITS-1:0];
            s1_cx_reg  <= s1_cx_next;
            s1_cy_reg  <= s1_cy_next;
            s1_ax_reg  <= s1_ax_next;
            s1_ay_reg  <= s1_ay_next;
        end
        if (en2)
        begin
            s2_op_reg  <= s1_op_reg;
            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
            s2_cy_reg  <= s1_cy_reg;
            s2_xf_reg  <= s1_xf_reg;
            s2_yf_reg  <= s1_yf_reg;
            s2_mx_reg  <= s2_mx_next;
            s2_my_reg  <= s2_my_next;
        end
        if (en3)
        begin
            s3_xf_reg <= s2_xf_reg;
            s3_yf_reg <= s2_yf_reg;
            s3_mx_reg <= s3_mx_next;
            s3_my_reg <= s3_my_next;
        end
        if (en4)
        begin
            s4_dbl_reg <= s4_dbl_next;
            s4_dtl_reg <= s4_dtl_next;
            s4_dbr_reg <= s4_dbr_next;
            s4_dtr_reg <= s4_dtr_next;
            s4_xf_reg  <= s3_xf_reg;
            s4_yf_reg  <= s3_yf_reg;
            s4_mx_reg  <= s4_mx_next;
            s4_my_reg  <= s4_my_next;
        end
        if (en5)
        begin
            s5_fu_reg   <= s5_fu_next;
            s5_fv_reg   <= s5_fv_next;
            s5_dbl_reg  <= s4_dbl_reg;
            s5_dbr_reg  <= s4_dbr_reg;
            s5_dif0_reg <= s5_dif0_next;
            s5_dif1_reg <= s5_dif1_next;
        end
        if (en6)
        begin
            s6_fu_reg <= s5_fu_reg;
            s6_l0_reg <= s6_l0_next;
            s6_l1_reg <= s6_l1_next;
        end
        if (en7)
        begin
            s7_fu_reg    <= s6_fu_reg;
            s7_l0_reg    <= s6_l0_reg;
            s7_ldiff_reg <= s7_ldiff_next;
        end
        if (en8)
        begin
            s8_noise_reg <= s8_noise_next;
        end
        if (en_out)
        begin
            res_noise_reg  <= s8_noise_reg;
            res_height_reg <= res_height_next;
            res_pass_reg   <= res_pass_next;
        end
    end

    assign result.valid          = res_v_reg;
    assign result.noise_value    = res_noise_reg;
    assign result.terrain_height = res_height_reg;
    assign result.passable       = res_pass_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic res_clamped;

    assign res_clamped = (res_height_reg == HEIGHT_LOW) || (res_height_reg == HEIGHT_HIGH);

    `PN2D_CHECK(a_ready_when_free, !s1_v_reg, cmd.ready, "empty input stage not ready")
    `PN2D_CHECK_NEXT(a_write_dropped, l2_we, !s3_v_reg, "table write entered compute stages")
    `PN2D_CHECK_NEXT(a_result_moves, !res_v_reg && s8_v_reg, res_v_reg, "sample not moved out")
    `PN2D_CHECK(a_clamp_height, res_v_reg && !res_pass_reg, res_clamped, "height not clamped")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 2D gradient noise terrain sampler
// Loads the permutation table, runs directed corner and clamp samples, then
// a long random mix of table writes and samples under random back-pressure.
// Every accepted sample is predicted in order and each returned item is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import pn2d_pkg::*;

    localparam int      FRAC        = 16;
    localparam longint  ONE_Q       = longint'(1) << FRAC;
    localparam int      LATENCY     = 8;
    localparam int      RANDOM_ITEMS = 576;
    localparam int      HOLD_AT     = 200;      // samples checked before the long hold
    localparam int      HOLD_CYCLES = 80;
    localparam int      CYCLE_LIMIT = 400000;
    localparam int      SEEK_TRIES  = 20000;

    // one command item; barrier items are never driven, they just make the
    // sender wait until every outstanding sample has returned
    typedef struct {
        logic               barrier;
        logic               opcode;
        logic [IDX_W-1:0]   table_index;
        logic [PERM_W-1:0]  table_value;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } cmd_item_t;

    typedef struct {
        logic signed [NOISE_W-1:0] noise;
        logic [HEIGHT_W-1:0]       height;
        logic                      passable;
    } terrain_sample_t;

    typedef enum int { SEEK_LOW, SEEK_HIGH, SEEK_HALF, SEEK_PASS } seek_t;

    logic clk;
    logic rst_n;

    pn2d_cmd_if    cmd_ch();
    pn2d_result_if res_ch();

    perlin_noise_2d_terrain #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch.sink),
        .result (res_ch.source)
    );

    // ------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------
    cmd_item_t       cmd_queue[$];        // items waiting to be offered
    terrain_sample_t terrain_expected[$]; // predictions, oldest first
    logic [PERM_W-1:0] perm_shadow [TABLE_SIZE]; // table as seen by accepted items

    int  cycles;
    int  n_errors;
    int  n_writes, n_samples, n_checked;
    int  n_low, n_high, n_pass, n_half;
    int  in_stall_run, in_stall_max;
    int  hold_left;
    bit  hold_done;
    bit  cmd_taken;

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.opcode        = OP_WRITE;
        cmd_ch.table_index   = '0;
        cmd_ch.table_value   = '0;
        cmd_ch.coord_x       = '0;
        cmd_ch.coord_y       = '0;
        res_ch.ready         = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Noise predictor: fixed point with FRAC fraction bits, every product
    // floored back to FRAC bits (arithmetic shift on a signed product).
    // ------------------------------------------------------------------
    function automatic longint mul_q(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    // quintic fade 6t^5 - 15t^4 + 10t^3, Horner form, each product floored
    function automatic longint fade_q(longint t);
        longint a;
        a = 6 * t - 15 * ONE_Q;
        a = mul_q(a, t) + 10 * ONE_Q;
        a = mul_q(a, t);
        a = mul_q(a, t);
        return mul_q(a, t);
    endfunction

    function automatic longint lerp_q(longint t, longint a, longint b);
        return a + mul_q(t, b - a);
    endfunction

    // gradient picked by hash mod 3: (1,1), (-1,1), (-1,-1)
    function automatic longint corner_dot(int unsigned hash, longint dx, longint dy);
        case (hash % 3)
            GRAD_PP: return dx + dy;
            GRAD_NP: return dy - dx;
            default: return -dx - dy;
        endcase
    endfunction

    function automatic int unsigned corner_hash(int unsigned cx, int unsigned cy);
        int unsigned inner;
        inner = perm_shadow[cx % TABLE_SIZE];
        return perm_shadow[(inner + cy) % TABLE_SIZE];
    endfunction

    function automatic terrain_sample_t predict_terrain(logic [COORD_W-1:0] x,
                                                        logic [COORD_W-1:0] y);
        terrain_sample_t res;
        int unsigned cx, cy;
        longint xf, yf, u, v, d_bl, d_tl, d_br, d_tr, noise, h;
        cx = (x >> FRAC) % CELL_MOD;    // cell wraps at 255, not 256
        cy = (y >> FRAC) % CELL_MOD;
        xf = x & ((32'd1 << FRAC) - 1);
        yf = y & ((32'd1 << FRAC) - 1);
        d_tr = corner_dot(corner_hash(cx + 1, cy + 1), xf - ONE_Q, yf - ONE_Q);
        d_tl = corner_dot(corner_hash(cx, cy + 1), xf, yf - ONE_Q);
        d_br = corner_dot(corner_hash(cx + 1, cy), xf - ONE_Q, yf);
        d_bl = corner_dot(corner_hash(cx, cy), xf, yf);
        u = fade_q(xf);
        v = fade_q(yf);
        noise = lerp_q(u, lerp_q(v, d_bl, d_tl), lerp_q(v, d_br, d_tr));
        if (noise > NOISE_MAX)
        begin
            noise = NOISE_MAX;
        end
        if (noise < NOISE_MIN)
        begin
            noise = NOISE_MIN;
        end
        // height = 16*noise + 4, clamped at/below 0.5 and at/above 9.5
        h = 16 * noise + 4 * ONE_Q;
        res.noise = noise[NOISE_W-1:0];
        if (h <= ONE_Q / 2)
        begin
            res.height   = HEIGHT_LOW;
            res.passable = 1'b0;
        end
        else if (h >= 9 * ONE_Q + ONE_Q / 2)
        begin
            res.height   = HEIGHT_HIGH;
            res.passable = 1'b0;
        end
        else
        begin
            res.height   = HEIGHT_W'((h + ONE_Q / 2) >>> FRAC);
            res.passable = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        int unsigned r;
        logic [COORD_W-1:0] c;
        r = $urandom_range(0, 9);
        c = $urandom();
        if (r >= 5 && r < 7)
        begin
            c[31:16] = 16'($urandom_range(0, 600));
        end
        else if (r == 7)
        begin
            // integer parts at and just below multiples of 255 (cell wrap)
            c[31:16] = 16'(255 * $urandom_range(0, 256) + ($urandom_range(0, 1) ? 254 : 0));
        end
        else if (r == 8)
        begin
            case ($urandom_range(0, 3))
                0: c[15:0] = 16'h0000;
                1: c[15:0] = 16'h0001;
                2: c[15:0] = 16'h8000;
                default: c[15:0] = 16'hFFFF;
            endcase
        end
        else if (r == 9)
        begin
            c[31:16] = 16'hFFFF - 16'($urandom_range(0, 3));
        end
        return c;
    endfunction

    function automatic cmd_item_t make_write(int idx, int val);
        cmd_item_t it;
        it             = '{default: '0};
        it.opcode      = OP_WRITE;
        it.table_index = IDX_W'(idx);
        it.table_value = PERM_W'(val);
        it.coord_x     = $urandom();    // ignored by a write, kept noisy
        it.coord_y     = $urandom();
        return it;
    endfunction

    function automatic cmd_item_t make_sample(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
        cmd_item_t it;
        it             = '{default: '0};
        it.opcode      = OP_EVAL;
        it.table_index = IDX_W'($urandom());
        it.table_value = PERM_W'($urandom());
        it.coord_x     = x;
        it.coord_y     = y;
        return it;
    endfunction

    // hunt for coordinates that land in a given height regime against the
    // table as it stands now; falls back to the last try if none is found
    function automatic cmd_item_t seek_sample(seek_t kind);
        terrain_sample_t p;
        logic [COORD_W-1:0] x, y;
        bit hit;
        hit = 1'b0;
        for (int i = 0; i < SEEK_TRIES && !hit; i++)
        begin
            x = rand_coord();
            y = rand_coord();
            p = predict_terrain(x, y);
            case (kind)
                SEEK_LOW:  hit = (p.height == HEIGHT_LOW) && !p.passable;
                SEEK_HIGH: hit = (p.height == HEIGHT_HIGH) && !p.passable;
                SEEK_HALF: hit = p.passable && (p.noise[11:0] == 12'h800);
                default:   hit = p.passable;
            endcase
        end
        return make_sample(x, y);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Command driver: changes inputs on the falling edge. A new item is
    // picked once the previous one was taken at the last rising edge.
    // ------------------------------------------------------------------
    int  tx_gap_left;
    int  tx_phase_left;
    bit  tx_calm;

    always @(negedge clk)
    begin
        cmd_item_t it;
        if (rst_n && (!cmd_ch.valid || cmd_taken))
        begin
            cmd_taken = 1'b0;
            // occasional stretches with no idling at all
            if (tx_phase_left == 0)
            begin
                tx_calm       = ($urandom_range(0, 3) == 0);
                tx_phase_left = $urandom_range(50, 200);
            end
            else
            begin
                tx_phase_left--;
            end
            if (tx_gap_left > 0 && hold_left == 0)
            begin
                tx_gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_queue.size() == 0)
            begin
                cmd_ch.valid <= 1'b0;
            end
            else if (cmd_queue[0].barrier)
            begin
                // sender pause: wait for every outstanding result
                cmd_ch.valid <= 1'b0;
                if (terrain_expected.size() == 0)
                begin
                    void'(cmd_queue.pop_front());
                end
            end
            else
            begin
                it = cmd_queue.pop_front();
                cmd_ch.valid       <= 1'b1;
                cmd_ch.opcode      <= it.opcode;
                cmd_ch.table_index <= it.table_index;
                cmd_ch.table_value <= it.table_value;
                cmd_ch.coord_x     <= it.coord_x;
                cmd_ch.coord_y     <= it.coord_y;
                tx_gap_left = tx_calm ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready generator: random stalls, calm stretches, and one long
    // hold once enough samples have been checked so the pipe backs up
    // into the command channel.
    // ------------------------------------------------------------------
    int  rx_stall_left;
    int  rx_phase_left;
    bit  rx_calm;

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            if (rx_phase_left == 0)
            begin
                rx_calm       = ($urandom_range(0, 3) == 0);
                rx_phase_left = $urandom_range(50, 200);
            end
            else
            begin
                rx_phase_left--;
            end
            if (!hold_done && n_checked >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= 1'b1;
                rx_stall_left = rx_calm ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: on the rising edge, record accepted commands (updating the
    // shadow table and pushing predictions) and check returned items.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        terrain_sample_t exp_s;
        terrain_sample_t got;
        if (rst_n)
        begin
            cycles++;

            if (cmd_ch.valid && !cmd_ch.ready)
            begin
                in_stall_run++;
                if (in_stall_run > in_stall_max)
                begin
                    in_stall_max = in_stall_run;
                end
            end
            else
            begin
                in_stall_run = 0;
            end

            if (cmd_ch.valid && cmd_ch.ready)
            begin
                cmd_taken = 1'b1;
                if (cmd_ch.opcode == OP_WRITE)
                begin
                    perm_shadow[cmd_ch.table_index] = cmd_ch.table_value;
                    n_writes++;
                end
                else
                begin
                    exp_s = predict_terrain(cmd_ch.coord_x, cmd_ch.coord_y);
                    terrain_expected.push_back(exp_s);
                    n_samples++;
                    if (!exp_s.passable && exp_s.height == HEIGHT_LOW)
                    begin
                        n_low++;
                    end
                    else if (!exp_s.passable)
                    begin
                        n_high++;
                    end
                    else
                    begin
                        n_pass++;
                        if (exp_s.noise[11:0] == 12'h800)
                        begin
                            n_half++;
                        end
                    end
                end
            end

            if (res_ch.valid && res_ch.ready)
            begin
                got.noise    = res_ch.noise_value;
                got.height   = res_ch.terrain_height;
                got.passable = res_ch.passable;
                n_checked++;
                if (terrain_expected.size() == 0)
                begin
                    report_mismatch($sformatf("result with no sample outstanding: noise %0d",
                                              got.noise));
                end
                else
                begin
                    exp_s = terrain_expected.pop_front();
                    if (got.noise !== exp_s.noise)
                    begin
                        report_mismatch($sformatf("noise_value %0d, expected %0d",
                                                  got.noise, exp_s.noise));
                    end
                    if (got.height !== exp_s.height)
                    begin
                        report_mismatch($sformatf("terrain_height %0d, expected %0d",
                                                  got.height, exp_s.height));
                    end
                    if (got.passable !== exp_s.passable)
                    begin
                        report_mismatch($sformatf("passable %0b, expected %0b",
                                                  got.passable, exp_s.passable));
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, terrain_expected.size());
        $display("[perlin_noise_2d_terrain] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        cmd_item_t barrier_item;
        cmd_item_t it;

        barrier_item         = '{default: '0};
        barrier_item.barrier = 1'b1;

        // Table load: identity pattern, so every entry is defined before any
        // sample and all three gradient residues show up.
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            cmd_queue.push_back(make_write(i, i));
        end
        while (cmd_queue.size() != 0 || cmd_ch.valid)
        begin
            @(posedge clk);
        end

        // Directed samples: coordinate extremes, the 255 cell wrap, tiny and
        // near-one fractions, then points chosen for each height regime.
        cmd_queue.push_back(make_sample(32'h0000_0000, 32'h0000_0000));
        cmd_queue.push_back(make_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF));
        cmd_queue.push_back(make_sample(32'h0000_0000, 32'hFFFF_FFFF));
        cmd_queue.push_back(make_sample(32'hFFFF_FFFF, 32'h0000_0000));
        cmd_queue.push_back(make_sample(32'h00FE_8000, 32'h00FE_8000));
        cmd_queue.push_back(make_sample(32'h00FF_0000, 32'h00FF_FFFF));
        cmd_queue.push_back(make_sample(32'h0000_0001, 32'h0000_FFFF));
        cmd_queue.push_back(make_sample(32'h00FE_FFFF, 32'h0001_0000));
        cmd_queue.push_back(seek_sample(SEEK_LOW));
        cmd_queue.push_back(seek_sample(SEEK_LOW));
        cmd_queue.push_back(seek_sample(SEEK_HIGH));
        cmd_queue.push_back(seek_sample(SEEK_HIGH));
        cmd_queue.push_back(seek_sample(SEEK_HALF));
        cmd_queue.push_back(seek_sample(SEEK_PASS));
        // write immediately followed by a sample that reads the new entry
        cmd_queue.push_back(make_write(5, 200));
        cmd_queue.push_back(make_sample(32'h0005_4000, 32'h0005_C000));
        cmd_queue.push_back(make_write(5, 5));
        cmd_queue.push_back(make_sample(32'h0005_4000, 32'h0005_C000));
        cmd_queue.push_back(barrier_item);

        // Random mix: mostly samples, some table rewrites, one sender pause
        // midway.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 2)
            begin
                cmd_queue.push_back(barrier_item);
            end
            if ($urandom_range(0, 99) < 15)
            begin
                it = make_write($urandom_range(0, 255), $urandom_range(0, 255));
            end
            else
            begin
                it = make_sample(rand_coord(), rand_coord());
            end
            cmd_queue.push_back(it);
        end

        while (cmd_queue.size() != 0 || cmd_ch.valid)
        begin
            @(posedge clk);
        end
        while (terrain_expected.size() != 0)
        begin
            @(posedge clk);
        end
        // drain window: catch any stray result after the last expected one
        repeat (LATENCY * 4) @(posedge clk);

        $display("covered %0d table writes and %0d samples: %0d low clamp, %0d high clamp,",
                 n_writes, n_samples, n_low, n_high);
        $display("  %0d passable (%0d on a rounding half), longest input stall %0d cycles",
                 n_pass, n_half, in_stall_max);
        if (n_errors == 0)
        begin
            $display("[perlin_noise_2d_terrain] OK");
        end
        else
        begin
            $display("%0d mismatches", n_errors);
            $display("[perlin_noise_2d_terrain] ERROR");
        end
        $finish;
    end

endmodule

// ----- perlin_noise_2d_terrain.f -----
+incdir+design
design/pn2d_pkg.sv
design/pn2d_if.sv
design/perlin_noise_2d_terrain.sv
verif/tb_top.sv
